FILE: hdl/rm_pkg.sv
// Shared types and codes for the running median block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package rm_pkg;

    typedef logic signed [15:0] t_sample;

    typedef struct packed {
        t_sample sample;
        logic    restart;
    } t_in;

    typedef struct packed {
        t_sample    median;
        logic [6:0] held_count;
        logic       full_res;
    } t_out;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INS,
        OP_PULL,
        OP_PUSH
    } t_chain_op;

    typedef struct packed {
        t_chain_op op;
        logic      desc;
        t_sample   sample;
        t_sample   inject;
    } t_chain_ctrl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BAL,
        ST_FIN
    } t_state;

endpackage

FILE: hdl/rm_cell.sv
// One cell of a sorted chain: holds a single sample and trades it with its neighbours.
// Depends on rm_pkg.
`timescale 1ns / 1ps

module rm_cell (
    input  logic                i_clk,
    input  rm_pkg::t_chain_ctrl i_ctrl,
    input  logic                i_valid,
    input  rm_pkg::t_sample     i_prev_value,
    input  logic                i_prev_stay,
    input  rm_pkg::t_sample     i_next_value,
    output rm_pkg::t_sample     o_value,
    output logic                o_stay
);
    import rm_pkg::*;

    t_sample r_value;
    t_sample n_value;
    logic    w_keep;

    always_comb begin
        if (i_ctrl.desc) begin
            w_keep = (r_value >= i_ctrl.sample);
        end else begin
            w_keep = (r_value <= i_ctrl.sample);
        end
        o_stay = i_valid && w_keep;
    end

    // On insertion the first cell that does not keep its value takes the sample,
    // and every cell beyond it takes the value of its neighbour nearer the head.
    always_comb begin
        case (i_ctrl.op)
            OP_INS: begin
                if (o_stay) begin
                    n_value = r_value;
                end else if (i_prev_stay) begin
                    n_value = i_ctrl.sample;
                end else begin
                    n_value = i_prev_value;
                end
            end
            OP_PULL: n_value = i_next_value;
            OP_PUSH: n_value = i_prev_value;
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

FILE: hdl/rm_chain.sv
// A row of rm_cell instances kept sorted away from the head cell.
// Depends on rm_pkg and rm_cell.
`timescale 1ns / 1ps

module rm_chain #(
    parameter int  DEPTH = 33,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                i_clk,
    input  rm_pkg::t_chain_ctrl i_ctrl,
    input  logic [CNT_W-1:0]    i_count,
    output rm_pkg::t_sample     o_head
);
    import rm_pkg::*;

    t_sample w_value [DEPTH];
    logic    w_stay  [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_sample w_prev_value;
        logic    w_prev_stay;
        t_sample w_next_value;

        // The head cell sees the injected value and behaves as if a keeping
        // neighbour stood before it.
        if (g == 0) begin : g_head
            assign w_prev_value = i_ctrl.inject;
            assign w_prev_stay  = 1'b1;
        end else begin : g_body
            assign w_prev_value = w_value[g-1];
            assign w_prev_stay  = w_stay[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_next_value = w_value[g];
        end else begin : g_inner
            assign w_next_value = w_value[g+1];
        end

        rm_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (i_ctrl),
            .i_valid      (CNT_W'(g) < i_count),
            .i_prev_value (w_prev_value),
            .i_prev_stay  (w_prev_stay),
            .i_next_value (w_next_value),
            .o_value      (w_value[g]),
            .o_stay       (w_stay[g])
        );
    end

    assign o_head = w_value[0];

endmodule

FILE: hdl/running_median.sv
// Running median of a stream of signed 16-bit samples.
// Depends on rm_pkg and rm_chain (which uses rm_cell).
//
// Input channel: i_in_valid / o_in_stall with i_in_data (sample, restart).
// A request is taken on a rising edge with valid high and stall low. A set
// restart flag discards the held stream and starts a new one with that sample.
// Output channel: o_out_valid / i_out_stall with o_out_data (median,
// held_count, full_res); one result request for every input request.
//
// The held samples sit in two sorted chains of cells: the lower half, largest
// at its head, and the upper half, smallest at its head. A sample is inserted
// at the edge that accepts it, the halves are rebalanced at the next edge by
// moving one head across, and the result is then loaded into the output
// register. A sample dropped because the store is full is not inserted and
// skips the rebalance. A new sample is taken in the cycle after the previous
// result has been loaded. While the receiver stalls, a held result stays
// stable, the next sample is still taken and worked, and it waits in the
// final step until the output register frees. Reset empties the store and
// clears the result valid; no clearing pass is needed.
`timescale 1ns / 1ps

module running_median #(
    parameter int CAPACITY = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  rm_pkg::t_in  i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output rm_pkg::t_out o_out_data
);
    import rm_pkg::*;

    localparam int HCAP = CAPACITY / 2 + 1;
    localparam int HW   = $clog2(HCAP + 1);
    localparam int CW   = $clog2(CAPACITY + 1);

    t_state      r_state, n_state;
    logic [HW-1:0] r_lcnt, n_lcnt;
    logic [HW-1:0] r_ucnt, n_ucnt;
    logic        r_dropped, n_dropped;
    logic        r_out_valid, n_out_valid;
    t_out        r_out_data, n_out_data;

    t_chain_ctrl w_lctrl, w_uctrl;
    t_sample     w_lhead, w_uhead;
    logic [HW-1:0] w_eff_l, w_eff_u;
    logic [CW-1:0] w_total, w_held;
    logic        w_in_acc, w_full, w_to_low, w_out_load;
    logic [HW:0] w_lcnt_x, w_ucnt_x, w_ucnt_p1;
    logic signed [16:0] w_sum, w_sum_adj;
    t_sample     w_median;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // A restart empties both halves before the sample is placed.
    assign w_eff_l  = (w_in_acc && i_in_data.restart) ? '0 : r_lcnt;
    assign w_eff_u  = (w_in_acc && i_in_data.restart) ? '0 : r_ucnt;
    assign w_total  = CW'(w_eff_l) + CW'(w_eff_u);
    assign w_full   = (w_total >= CW'(CAPACITY));
    assign w_to_low = (w_eff_l == '0) || (i_in_data.sample <= w_lhead);

    assign w_lcnt_x  = (HW+1)'(r_lcnt);
    assign w_ucnt_x  = (HW+1)'(r_ucnt);
    assign w_ucnt_p1 = (HW+1)'(r_ucnt) + (HW+1)'(1);

    assign w_out_load = (r_state == ST_FIN) && (!r_out_valid || !i_out_stall);

    // Even count: average of the two heads, rounded toward zero.
    assign w_held    = CW'(r_lcnt) + CW'(r_ucnt);
    assign w_sum     = 17'(w_lhead) + 17'(w_uhead);
    assign w_sum_adj = w_sum + 17'(w_sum[16] & w_sum[0]);
    assign w_median  = w_held[0] ? w_lhead : t_sample'(w_sum_adj[16:1]);

    rm_chain #(.DEPTH(HCAP)) u_low (
        .i_clk   (i_clk),
        .i_ctrl  (w_lctrl),
        .i_count (w_eff_l),
        .o_head  (w_lhead)
    );

    rm_chain #(.DEPTH(HCAP)) u_high (
        .i_clk   (i_clk),
        .i_ctrl  (w_uctrl),
        .i_count (w_eff_u),
        .o_head  (w_uhead)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_full ? ST_FIN : ST_BAL;
                end
            end
            ST_BAL:  n_state = ST_FIN;
            ST_FIN: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_lctrl = '{op: OP_HOLD, desc: 1'b1, sample: i_in_data.sample, inject: w_uhead};
        w_uctrl = '{op: OP_HOLD, desc: 1'b0, sample: i_in_data.sample, inject: w_lhead};
        n_lcnt      = r_lcnt;
        n_ucnt      = r_ucnt;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_dropped = w_full;
                    n_lcnt    = w_eff_l;
                    n_ucnt    = w_eff_u;
                    if (!w_full) begin
                        if (w_to_low) begin
                            w_lctrl.op = OP_INS;
                            n_lcnt     = w_eff_l + HW'(1);
                        end else begin
                            w_uctrl.op = OP_INS;
                            n_ucnt     = w_eff_u + HW'(1);
                        end
                    end
                end
            end
            ST_BAL: begin
                // The lower half holds the extra sample of an odd count.
                if (w_lcnt_x > w_ucnt_p1) begin
                    w_lctrl.op = OP_PULL;
                    w_uctrl.op = OP_PUSH;
                    n_lcnt     = r_lcnt - HW'(1);
                    n_ucnt     = r_ucnt + HW'(1);
                end else if (w_ucnt_x > w_lcnt_x) begin
                    w_uctrl.op = OP_PULL;
                    w_lctrl.op = OP_PUSH;
                    n_ucnt     = r_ucnt - HW'(1);
                    n_lcnt     = r_lcnt + HW'(1);
                end
            end
            ST_FIN: begin
                if (w_out_load) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '{median: w_median, held_count: 7'(w_held),
                                    full_res: r_dropped};
                end
            end
            default: begin
                n_out_valid = r_out_valid && i_out_stall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lcnt      <= '0;
            r_ucnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lcnt      <= n_lcnt;
            r_ucnt      <= n_ucnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dropped  <= n_dropped;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: hdl/rm_checker.sv
// Port-level checks for running_median, attached to it by the bind below.
// Depends on rm_pkg and on the running_median port list.
`timescale 1ns / 1ps

module rm_checker #(
    parameter int CAPACITY = 64
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_valid,
    input logic         o_in_stall,
    input rm_pkg::t_in  i_in_data,
    input logic         o_out_valid,
    input logic         i_out_stall,
    input rm_pkg::t_out o_out_data
);
    import rm_pkg::*;

    logic w_in_acc;
    assign w_in_acc = i_in_valid && !o_in_stall;

    // A stalled result request holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result request changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Samples are worked one at a time, so an accepted request blocks the next.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("second request accepted while one is in work");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.full_res |-> o_out_data.held_count == 7'(CAPACITY))
        else $error("dropped sample reported with a store that is not full");

    a_never_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.held_count != 7'd0 || CAPACITY >= 128)
        else $error("result reports an empty store");

endmodule

bind running_median rm_checker #(.CAPACITY(CAPACITY)) u_rm_checker (.*);

FILE: dv/running_median_checker.sv
// Checker for the running median block: watches both request channels, predicts each
// result from its own sorted copy of the stream and compares field by field.
// Depends on rm_pkg only.
`timescale 1ns / 1ps

module running_median_checker #(
    parameter int CAPACITY = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_stall,
    input  rm_pkg::t_in  i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_stall,
    input  rm_pkg::t_out i_out_data,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_checked,
    output int           o_drops
);

    import rm_pkg::*;

    t_sample stream_sorted[CAPACITY];
    int      stream_len;
    t_out    medians_due[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_drops      = 0;
        stream_len   = 0;
    end

    // Inserts the sample at its sorted place (unless the copy is full) and returns the median of the stream.
    function automatic t_out take_sample(t_in req);
        t_out    res;
        t_sample v;
        int      pos;
        int      half;
        int      pair_sum;
        logic    dropped;
        v = req.sample;
        if (req.restart) begin
            stream_len = 0;
        end
        dropped = (stream_len >= CAPACITY);
        if (!dropped) begin
            pos = stream_len;
            while (pos > 0 && stream_sorted[pos - 1] > v) begin
                stream_sorted[pos] = stream_sorted[pos - 1];
                pos--;
            end
            stream_sorted[pos] = v;
            stream_len++;
        end
        half = stream_len / 2;
        if (stream_len % 2 == 1) begin
            res.median = stream_sorted[half];
        end else begin
            // Integer division in SV truncates toward zero, as required here.
            pair_sum   = int'(stream_sorted[half - 1]) + int'(stream_sorted[half]);
            res.median = t_sample'(pair_sum / 2);
        end
        res.held_count = 7'(stream_len);
        res.full_res   = dropped;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out due;
        t_out got;
        if (!i_rst_n) begin
            stream_len = 0;
            medians_due.delete();
        end else begin
            // The result channel is handled first: a request taken at this edge cannot
            // produce its result at the same edge.
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (medians_due.size() == 0) begin
                    $display("%0t: result with nothing expected: median %0d count %0d full %0b",
                             $time, $signed(got.median), got.held_count, got.full_res);
                    o_fail_count++;
                end else begin
                    due = medians_due.pop_front();
                    o_checked++;
                    if (got.median !== due.median) begin
                        $display("%0t: median expected %0d, actual %0d",
                                 $time, $signed(due.median), $signed(got.median));
                        o_fail_count++;
                    end
                    if (got.held_count !== due.held_count) begin
                        $display("%0t: held_count expected %0d, actual %0d",
                                 $time, due.held_count, got.held_count);
                        o_fail_count++;
                    end
                    if (got.full_res !== due.full_res) begin
                        $display("%0t: full_res expected %0b, actual %0b",
                                 $time, due.full_res, got.full_res);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                due = take_sample(i_in_data);
                if (due.full_res) begin
                    o_drops++;
                end
                medians_due.push_back(due);
            end
        end
        o_pending = medians_due.size();
    end

endmodule

FILE: dv/running_median_tb.sv
// Top of the running median testbench: clock, reset, sample stimulus and result stalls.
// Depends on rm_pkg, running_median and running_median_checker.
`timescale 1ns / 1ps

module running_median_tb;

    import rm_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int TOTAL_ITEMS  = 950;
    localparam int QUIET_ITEMS  = 120;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic in_valid    = 1'b0;
    logic in_stall;
    t_in  in_data     = '0;
    logic out_valid;
    logic out_stall   = 1'b0;
    t_out out_data;

    int   fail_count;
    int   pending;
    int   checked;
    int   drops;

    logic quiet_tail  = 1'b0;
    int   stall_left  = 0;
    int   stall_calm  = 0;
    int   send_calm   = 0;
    int   sent        = 0;
    int   streams     = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    running_median #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    running_median_checker #(
        .CAPACITY(CAPACITY)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_drops     (drops)
    );

    // Receiver stalls: bursts of random length, broken up by calm stretches.
    always @(posedge i_clk) begin : stall_gen
        logic nxt;
        nxt = 1'b0;
        if (i_rst_n && !quiet_tail) begin
            if (stall_left > 0) begin
                nxt = 1'b1;
                stall_left--;
            end else if (stall_calm > 0) begin
                stall_calm--;
            end else if ($urandom_range(0, 49) == 0) begin
                stall_calm = $urandom_range(20, 80);
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 8) - 1;
                nxt = 1'b1;
            end
        end
        out_stall <= nxt;
    end

    task automatic send_sample(input t_sample s, input logic rs);
        int gap;
        gap = 0;
        if (!quiet_tail) begin
            if (send_calm > 0) begin
                send_calm--;
            end else if ($urandom_range(0, 39) == 0) begin
                send_calm = $urandom_range(10, 60);
            end else if ($urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 8);
            end
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{sample: s, restart: rs};
        do @(posedge i_clk); while (in_stall);
        sent++;
        if (rs) begin
            streams++;
        end
    endtask

    // Holds off the sender until every outstanding result has been returned.
    // Waiting for the falling edge lets the checker record a request taken at this edge.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge i_clk);
        wait (pending == 0);
        @(posedge i_clk);
    endtask

    function automatic t_sample pick_sample();
        case ($urandom_range(0, 9))
            0, 1:    return t_sample'($urandom_range(0, 16) - 8);
            2: begin
                case ($urandom_range(0, 5))
                    0:       return 16'sh8000;
                    1:       return 16'sh7fff;
                    2:       return 16'sh8001;
                    3:       return 16'sh7ffe;
                    4:       return 16'sh0000;
                    default: return 16'shffff;
                endcase
            end
            default: return t_sample'($urandom());
        endcase
    endfunction

    task automatic send_stream(input int len);
        for (int k = 0; k < len; k++) begin
            send_sample(pick_sample(), k == 0);
        end
    endtask

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // First sample after reset without restart, then an even pair whose average is exact.
        send_sample(-16'sd5, 1'b0);
        send_sample(16'sd3, 1'b0);
        // Largest values: the pair sum must not wrap.
        send_sample(16'sh7fff, 1'b1);
        send_sample(16'sh7fff, 1'b0);
        // Smallest values, then a mixed pair whose average truncates to zero.
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        // Negative odd sum: truncation toward zero, not downward.
        send_sample(-16'sd3, 1'b1);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd2, 1'b0);
        // Repeated values and a small positive pair.
        send_sample(16'sd7, 1'b1);
        send_sample(16'sd7, 1'b0);
        send_sample(16'sd7, 1'b0);
        send_sample(16'sd1, 1'b1);
        send_sample(16'sd2, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd0, 1'b0);
        drain_results();

        // One stream that overruns the store, then a restart while it is full.
        send_stream(CAPACITY + 6);
        send_stream(3);

        while (sent < TOTAL_ITEMS) begin
            if (TOTAL_ITEMS - sent <= QUIET_ITEMS) begin
                quiet_tail = 1'b1;
            end
            if ($urandom_range(0, 11) == 0) begin
                drain_results();
            end
            if ($urandom_range(0, 4) == 0) begin
                send_stream($urandom_range(CAPACITY - 4, CAPACITY + 10));
            end else begin
                send_stream($urandom_range(1, 24));
            end
        end

        in_valid <= 1'b0;
        @(negedge i_clk);
        wait (pending == 0);
        repeat (10) @(posedge i_clk);
        $display("Sent %0d samples in %0d restarted streams; %0d results checked.",
                 sent, streams, checked);
        $display("%0d samples were dropped against a full store.", drops);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
